// ===== hdl/vbrj_pkg.sv =====
// Shared types, micro-op encoding and the microcode table of the bending-entry unit.
`default_nettype none
package vbrj_pkg;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_RES  = 2'd1;
  localparam logic [1:0] CMD_JAC  = 2'd2;

  localparam logic [1:0] CFG_EPSILON   = 2'd0;
  localparam logic [1:0] CFG_CURVATURE = 2'd1;
  localparam logic [1:0] CFG_AXISYM    = 2'd2;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_SCL = 3'd2;
  localparam logic [2:0] OP_MUL = 3'd3;
  localparam logic [2:0] OP_DIV = 3'd4;
  localparam logic [2:0] OP_BR  = 3'd5;
  localparam logic [2:0] OP_END = 3'd6;

  // operand sources: below 32 fixed registers, from 32 scratch entries
  localparam logic [5:0] S_W    = 6'd0;
  localparam logic [5:0] S_TX   = 6'd1;
  localparam logic [5:0] S_TY   = 6'd2;
  localparam logic [5:0] S_TZ   = 6'd3;
  localparam logic [5:0] S_LTI  = 6'd4;
  localparam logic [5:0] S_P    = 6'd5;
  localparam logic [5:0] S_PX   = 6'd6;
  localparam logic [5:0] S_PY   = 6'd7;
  localparam logic [5:0] S_PZ   = 6'd8;
  localparam logic [5:0] S_LPI  = 6'd9;
  localparam logic [5:0] S_PU   = 6'd10;
  localparam logic [5:0] S_PGX  = 6'd11;
  localparam logic [5:0] S_PGY  = 6'd12;
  localparam logic [5:0] S_PGZ  = 6'd13;
  localparam logic [5:0] S_PLAP = 6'd14;
  localparam logic [5:0] S_PRAD = 6'd15;
  localparam logic [5:0] S_EPS  = 6'd16;
  localparam logic [5:0] S_CUR  = 6'd17;
  localparam logic [5:0] S_ONE  = 6'd18;
  localparam logic [5:0] S_ZERO = 6'd19;

  localparam logic [5:0] R_LU  = 6'd32;
  localparam logic [5:0] R_LT  = 6'd33;
  localparam logic [5:0] R_LP  = 6'd34;
  localparam logic [5:0] R_T   = 6'd35;
  localparam logic [5:0] R_CE  = 6'd36;
  localparam logic [5:0] R_U2  = 6'd37;
  localparam logic [5:0] R_A   = 6'd38;
  localparam logic [5:0] R_B   = 6'd39;
  localparam logic [5:0] R_G   = 6'd40;
  localparam logic [5:0] R_H   = 6'd41;
  localparam logic [5:0] R_K   = 6'd42;
  localparam logic [5:0] R_IE  = 6'd43;
  localparam logic [5:0] R_I2  = 6'd44;
  localparam logic [5:0] R_IE3 = 6'd45;
  localparam logic [5:0] R_DTU = 6'd46;
  localparam logic [5:0] R_DUU = 6'd47;
  localparam logic [5:0] R_S6U = 6'd48;
  localparam logic [5:0] R_R   = 6'd49;
  localparam logic [5:0] R_DTP = 6'd50;
  localparam logic [5:0] R_DPU = 6'd51;
  localparam logic [5:0] R_M   = 6'd52;
  localparam logic [5:0] R_C   = 6'd53;

  localparam logic [2:0] K0 = 3'd0;
  localparam logic [2:0] K2 = 3'd2;
  localparam logic [2:0] K3 = 3'd3;
  localparam logic [2:0] K6 = 3'd6;

  typedef logic [6:0] upc_t;
  localparam upc_t JAC_PC = 7'd52;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] a_value;
    logic [31:0] a_grad_x;
    logic [31:0] a_grad_y;
    logic [31:0] a_grad_z;
    logic [31:0] a_laplacian;
    logic [31:0] b_value;
    logic [31:0] b_grad_x;
    logic [31:0] b_grad_y;
    logic [31:0] b_grad_z;
    logic [31:0] b_laplacian;
    logic [31:0] radius;
  } item_t;

  typedef struct packed {
    logic [31:0] entry_value;
    logic        radius_fault;
    logic        saturated;
  } result_t;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] sa;
    logic [5:0] sb;
    logic [4:0] dst;
    logic [2:0] k;
    logic       axi;
  } uop_t;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] k;
    logic       start;
  } alu_cmd_t;

  function automatic uop_t mk(input logic [2:0] op, input logic [5:0] sa,
                              input logic [5:0] sb, input logic [5:0] dst,
                              input logic [2:0] k, input logic axi);
    uop_t u;
    u.op  = op;
    u.sa  = sa;
    u.sb  = sb;
    u.dst = dst[4:0];
    u.k   = k;
    u.axi = axi;
    return u;
  endfunction

  function automatic uop_t ucode(input upc_t pc);
    uop_t u;
    unique case (pc)
      7'd0:   u = mk(OP_ADD, S_PLAP, S_ZERO, R_LU, K0, 1'b0);
      7'd1:   u = mk(OP_ADD, S_LTI, S_ZERO, R_LT, K0, 1'b0);
      7'd2:   u = mk(OP_ADD, S_LPI, S_ZERO, R_LP, K0, 1'b0);
      7'd3:   u = mk(OP_DIV, S_PGX, S_PRAD, R_T, K0, 1'b1);
      7'd4:   u = mk(OP_ADD, R_LU, R_T, R_LU, K0, 1'b1);
      7'd5:   u = mk(OP_DIV, S_TX, S_PRAD, R_T, K0, 1'b1);
      7'd6:   u = mk(OP_ADD, R_LT, R_T, R_LT, K0, 1'b1);
      7'd7:   u = mk(OP_DIV, S_PX, S_PRAD, R_T, K0, 1'b1);
      7'd8:   u = mk(OP_ADD, R_LP, R_T, R_LP, K0, 1'b1);
      7'd9:   u = mk(OP_MUL, S_CUR, S_EPS, R_CE, K0, 1'b0);
      7'd10:  u = mk(OP_MUL, S_PU, S_PU, R_U2, K0, 1'b0);
      7'd11:  u = mk(OP_SCL, R_U2, S_ZERO, R_A, K3, 1'b0);
      7'd12:  u = mk(OP_MUL, R_CE, S_PU, R_B, K0, 1'b0);
      7'd13:  u = mk(OP_SCL, R_B, S_ZERO, R_B, K2, 1'b0);
      7'd14:  u = mk(OP_ADD, R_A, R_B, R_G, K0, 1'b0);
      7'd15:  u = mk(OP_SUB, R_G, S_ONE, R_G, K0, 1'b0);
      7'd16:  u = mk(OP_SUB, R_U2, S_ONE, R_H, K0, 1'b0);
      7'd17:  u = mk(OP_ADD, S_PU, R_CE, R_K, K0, 1'b0);
      7'd18:  u = mk(OP_DIV, S_ONE, S_EPS, R_IE, K0, 1'b0);
      7'd19:  u = mk(OP_SCL, S_ONE, S_ZERO, R_I2, K2, 1'b0);
      7'd20:  u = mk(OP_DIV, R_I2, S_EPS, R_I2, K0, 1'b0);
      7'd21:  u = mk(OP_MUL, R_IE, R_IE, R_IE3, K0, 1'b0);
      7'd22:  u = mk(OP_MUL, R_IE3, R_IE, R_IE3, K0, 1'b0);
      7'd23:  u = mk(OP_MUL, S_TX, S_PGX, R_A, K0, 1'b0);
      7'd24:  u = mk(OP_MUL, S_TY, S_PGY, R_B, K0, 1'b0);
      7'd25:  u = mk(OP_ADD, R_A, R_B, R_A, K0, 1'b0);
      7'd26:  u = mk(OP_MUL, S_TZ, S_PGZ, R_B, K0, 1'b0);
      7'd27:  u = mk(OP_ADD, R_A, R_B, R_DTU, K0, 1'b0);
      7'd28:  u = mk(OP_MUL, S_PGX, S_PGX, R_A, K0, 1'b0);
      7'd29:  u = mk(OP_MUL, S_PGY, S_PGY, R_B, K0, 1'b0);
      7'd30:  u = mk(OP_ADD, R_A, R_B, R_A, K0, 1'b0);
      7'd31:  u = mk(OP_MUL, S_PGZ, S_PGZ, R_B, K0, 1'b0);
      7'd32:  u = mk(OP_ADD, R_A, R_B, R_DUU, K0, 1'b0);
      7'd33:  u = mk(OP_SCL, S_PU, S_ZERO, R_A, K6, 1'b0);
      7'd34:  u = mk(OP_SCL, R_CE, S_ZERO, R_B, K2, 1'b0);
      7'd35:  u = mk(OP_ADD, R_A, R_B, R_S6U, K0, 1'b0);
      7'd36:  u = mk(OP_BR, S_ZERO, S_ZERO, R_R, K0, 1'b0);
      // residual
      7'd37:  u = mk(OP_MUL, R_LT, R_LU, R_R, K0, 1'b0);
      7'd38:  u = mk(OP_MUL, S_EPS, R_R, R_R, K0, 1'b0);
      7'd39:  u = mk(OP_MUL, R_I2, R_DTU, R_A, K0, 1'b0);
      7'd40:  u = mk(OP_MUL, R_A, R_G, R_A, K0, 1'b0);
      7'd41:  u = mk(OP_ADD, R_R, R_A, R_R, K0, 1'b0);
      7'd42:  u = mk(OP_MUL, R_IE, S_W, R_A, K0, 1'b0);
      7'd43:  u = mk(OP_MUL, R_A, R_S6U, R_A, K0, 1'b0);
      7'd44:  u = mk(OP_MUL, R_A, R_DUU, R_A, K0, 1'b0);
      7'd45:  u = mk(OP_ADD, R_R, R_A, R_R, K0, 1'b0);
      7'd46:  u = mk(OP_MUL, R_IE3, S_W, R_A, K0, 1'b0);
      7'd47:  u = mk(OP_MUL, R_A, R_G, R_A, K0, 1'b0);
      7'd48:  u = mk(OP_MUL, R_A, R_H, R_A, K0, 1'b0);
      7'd49:  u = mk(OP_MUL, R_A, R_K, R_A, K0, 1'b0);
      7'd50:  u = mk(OP_ADD, R_R, R_A, R_R, K0, 1'b0);
      7'd51:  u = mk(OP_END, R_R, S_ZERO, R_R, K0, 1'b0);
      // jacobian
      7'd52:  u = mk(OP_MUL, S_TX, S_PX, R_A, K0, 1'b0);
      7'd53:  u = mk(OP_MUL, S_TY, S_PY, R_B, K0, 1'b0);
      7'd54:  u = mk(OP_ADD, R_A, R_B, R_A, K0, 1'b0);
      7'd55:  u = mk(OP_MUL, S_TZ, S_PZ, R_B, K0, 1'b0);
      7'd56:  u = mk(OP_ADD, R_A, R_B, R_DTP, K0, 1'b0);
      7'd57:  u = mk(OP_MUL, S_PX, S_PGX, R_A, K0, 1'b0);
      7'd58:  u = mk(OP_MUL, S_PY, S_PGY, R_B, K0, 1'b0);
      7'd59:  u = mk(OP_ADD, R_A, R_B, R_A, K0, 1'b0);
      7'd60:  u = mk(OP_MUL, S_PZ, S_PGZ, R_B, K0, 1'b0);
      7'd61:  u = mk(OP_ADD, R_A, R_B, R_DPU, K0, 1'b0);
      7'd62:  u = mk(OP_SCL, S_PU, S_ZERO, R_A, K6, 1'b0);
      7'd63:  u = mk(OP_MUL, R_A, S_P, R_A, K0, 1'b0);
      7'd64:  u = mk(OP_SCL, R_CE, S_ZERO, R_B, K2, 1'b0);
      7'd65:  u = mk(OP_MUL, R_B, S_P, R_B, K0, 1'b0);
      7'd66:  u = mk(OP_ADD, R_A, R_B, R_M, K0, 1'b0);
      7'd67:  u = mk(OP_MUL, S_EPS, R_LT, R_R, K0, 1'b0);
      7'd68:  u = mk(OP_MUL, R_R, R_LP, R_R, K0, 1'b0);
      7'd69:  u = mk(OP_MUL, R_I2, R_DTP, R_A, K0, 1'b0);
      7'd70:  u = mk(OP_MUL, R_A, R_G, R_A, K0, 1'b0);
      7'd71:  u = mk(OP_ADD, R_R, R_A, R_R, K0, 1'b0);
      7'd72:  u = mk(OP_MUL, R_I2, R_DTU, R_A, K0, 1'b0);
      7'd73:  u = mk(OP_MUL, R_A, R_M, R_A, K0, 1'b0);
      7'd74:  u = mk(OP_ADD, R_R, R_A, R_R, K0, 1'b0);
      7'd75:  u = mk(OP_MUL, R_IE, S_W, R_A, K0, 1'b0);
      7'd76:  u = mk(OP_SCL, S_P, S_ZERO, R_B, K6, 1'b0);
      7'd77:  u = mk(OP_MUL, R_A, R_B, R_A, K0, 1'b0);
      7'd78:  u = mk(OP_MUL, R_A, R_DUU, R_A, K0, 1'b0);
      7'd79:  u = mk(OP_ADD, R_R, R_A, R_R, K0, 1'b0);
      7'd80:  u = mk(OP_MUL, R_IE, S_W, R_A, K0, 1'b0);
      7'd81:  u = mk(OP_MUL, R_A, R_S6U, R_A, K0, 1'b0);
      7'd82:  u = mk(OP_SCL, R_DPU, S_ZERO, R_B, K2, 1'b0);
      7'd83:  u = mk(OP_MUL, R_A, R_B, R_A, K0, 1'b0);
      7'd84:  u = mk(OP_ADD, R_R, R_A, R_R, K0, 1'b0);
      7'd85:  u = mk(OP_MUL, R_IE3, S_W, R_C, K0, 1'b0);
      7'd86:  u = mk(OP_MUL, R_C, R_M, R_A, K0, 1'b0);
      7'd87:  u = mk(OP_MUL, R_A, R_H, R_A, K0, 1'b0);
      7'd88:  u = mk(OP_MUL, R_A, R_K, R_A, K0, 1'b0);
      7'd89:  u = mk(OP_ADD, R_R, R_A, R_R, K0, 1'b0);
      7'd90:  u = mk(OP_MUL, R_C, R_G, R_A, K0, 1'b0);
      7'd91:  u = mk(OP_SCL, S_PU, S_ZERO, R_B, K2, 1'b0);
      7'd92:  u = mk(OP_MUL, R_B, S_P, R_B, K0, 1'b0);
      7'd93:  u = mk(OP_MUL, R_A, R_B, R_A, K0, 1'b0);
      7'd94:  u = mk(OP_MUL, R_A, R_K, R_A, K0, 1'b0);
      7'd95:  u = mk(OP_ADD, R_R, R_A, R_R, K0, 1'b0);
      7'd96:  u = mk(OP_MUL, R_C, R_G, R_A, K0, 1'b0);
      7'd97:  u = mk(OP_MUL, R_A, R_H, R_A, K0, 1'b0);
      7'd98:  u = mk(OP_MUL, R_A, S_P, R_A, K0, 1'b0);
      7'd99:  u = mk(OP_ADD, R_R, R_A, R_R, K0, 1'b0);
      default: u = mk(OP_END, R_R, S_ZERO, R_R, K0, 1'b0);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/vbrj_chan.sv =====
// Valid/ready channel carrying one payload item per transfer.
`default_nettype none
interface vbrj_chan #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/vbrj_alu.sv =====
// Shared saturating fixed-point unit: add, subtract, scale, multiply, bit-serial divide.
`default_nettype none
module vbrj_alu
  import vbrj_pkg::*;
#(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire alu_cmd_t                     cmd,
  input  wire logic signed [WORD_WIDTH-1:0] a,
  input  wire logic signed [WORD_WIDTH-1:0] b,
  output logic signed [WORD_WIDTH-1:0]      res,
  output logic                              res_clip,
  output logic                              div_done
);
  localparam int W = WORD_WIDTH;
  localparam int NW = WORD_WIDTH + FRAC_BITS;
  localparam int MW = 2 * WORD_WIDTH + FRAC_BITS + 1;
  localparam int CW = $clog2(NW + 1);
  localparam logic signed [63:0] WMAX64 = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam logic signed [63:0] WMIN64 = -WMAX64 - 64'sd1;
  localparam logic [MW-1:0] LIMP = MW'(WMAX64);
  localparam logic [MW-1:0] LIMN = LIMP + MW'(1);
  localparam logic [2*W:0] HALF = (2*W+1)'(1) << (FRAC_BITS - 1);

  function automatic logic [W:0] from_mag(input logic neg, input logic [MW-1:0] mag);
    logic [MW-1:0] m;
    logic          c;
    m = mag;
    c = 1'b0;
    if (neg && mag > LIMN) begin
      m = LIMN;
      c = 1'b1;
    end else if (!neg && mag > LIMP) begin
      m = LIMP;
      c = 1'b1;
    end
    return {c, neg ? W'(-m) : W'(m)};
  endfunction

  function automatic logic [W:0] sat_s(input logic signed [W+3:0] v);
    logic signed [63:0] v64;
    v64 = 64'(v);
    if (v64 > WMAX64) return {1'b1, W'(WMAX64)};
    else if (v64 < WMIN64) return {1'b1, W'(WMIN64)};
    else return {1'b0, W'(v64)};
  endfunction

  logic [W-1:0]     ma, mb;
  logic [2*W-1:0]   prod;
  logic [2*W:0]     prod_r;
  logic [W:0]       r_add, r_sub, r_scl, r_mul, r_div;
  logic signed [W+3:0] k_s;

  // divider state
  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] num, q;
  logic [W-1:0]  den;
  logic [W:0]    rem, rsh;
  logic          dneg, dzero;
  logic [NW:0]   q1;
  logic          up;

  always_comb begin
    ma = a[W-1] ? W'(-a) : W'(a);
    mb = b[W-1] ? W'(-b) : W'(b);
    prod = {{W{1'b0}}, ma} * {{W{1'b0}}, mb};
    prod_r = {1'b0, prod} + HALF;
    k_s = (W+4)'(signed'({1'b0, cmd.k}));
    r_add = sat_s((W+4)'(a) + (W+4)'(b));
    r_sub = sat_s((W+4)'(a) - (W+4)'(b));
    r_scl = sat_s((W+4)'(a) * k_s);
    r_mul = from_mag(a[W-1] ^ b[W-1], MW'(prod_r >> FRAC_BITS));
    rsh = {rem[W-1:0], num[NW-1]};
    up = ({rem, 1'b0} >= {2'b00, den});
    q1 = {1'b0, q} + (NW+1)'(up);
    r_div = dzero ? '0 : from_mag(dneg, MW'(q1));
    div_done = busy && (cnt == '0);
    unique case (cmd.op)
      OP_ADD:  {res_clip, res} = r_add;
      OP_SUB:  {res_clip, res} = r_sub;
      OP_SCL:  {res_clip, res} = r_scl;
      OP_MUL:  {res_clip, res} = r_mul;
      OP_DIV:  {res_clip, res} = r_div;
      default: {res_clip, res} = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      cnt <= CW'(NW);
      num <= {ma, {FRAC_BITS{1'b0}}};
      den <= mb;
      rem <= '0;
      q <= '0;
      dneg <= a[W-1] ^ b[W-1];
      dzero <= (mb == '0);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - CW'(1);
        num <= num << 1;
        if (rsh >= {1'b0, den}) begin
          rem <= rsh - {1'b0, den};
          q <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= rsh;
          q <= {q[NW-2:0], 1'b0};
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/vesicle_bending_residual_jacobian.sv =====
// Top level: microcoded evaluator of vesicle bending residual and jacobian entries.
//
//   channel  dir  payload                         transfer when
//   item     in   opcode, a_*, b_*, radius        item.valid & item.ready
//   result   out  entry_value, radius_fault, sat  result.valid & result.ready
//   cfg      in   cfg_index, cfg_data             cfg_we
//
// An entry runs a microprogram on one shared unit: each micro-op passes an operand fetch
// state and an execute state; a divide then waits until the bit-serial divider is done.
// Residual: 46 micro-ops with 2 divides; jacobian: 80 micro-ops with 2 divides.
// Axisymmetric mode adds 3 divides and 3 adds; otherwise each of those 6 is skipped in the fetch state.
// item.ready is high only while idle; a result holds until taken. Sync reset, no clearing pass.
`default_nettype none
module vesicle_bending_residual_jacobian
  import vbrj_pkg::*;
#(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  vbrj_chan.sink           item,
  vbrj_chan.source         result,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int W = WORD_WIDTH;
  localparam logic signed [63:0] WMAX64 = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam logic signed [63:0] WMIN64 = -WMAX64 - 64'sd1;
  localparam logic signed [63:0] ONE64 = 64'sd1 <<< FRAC_BITS;
  localparam logic ONE_CLIP = ONE64 > WMAX64;
  localparam logic signed [W-1:0] ONE_W = ONE_CLIP ? W'(WMAX64) : W'(ONE64);
  localparam logic signed [63:0] OMAX64 = 64'sd2147483647;
  localparam logic signed [63:0] OMIN64 = -64'sd2147483648;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_DIVW = 3'd3;
  localparam logic [2:0] ST_OUT = 3'd4;

  function automatic logic signed [W-1:0] word_in(input logic [31:0] x);
    logic signed [63:0] v;
    v = 64'(signed'(x));
    if (v > WMAX64) v = WMAX64;
    else if (v < WMIN64) v = WMIN64;
    return W'(v);
  endfunction

  logic [2:0]  state;
  upc_t        pc;
  uop_t        uop, ufetch;
  logic        is_jac, clip;
  logic [30:0] epsilon;
  logic [31:0] curvature;
  logic        axisymmetric;
  result_t     out_item;

  logic signed [W-1:0] w, tx, ty, tz, lti, p, px, py, pz, lpi;
  logic signed [W-1:0] pu, pgx, pgy, pgz, plap, prad;
  logic signed [W-1:0] eps_w, cur_w;
  logic signed [W-1:0] opa_fix, opb_fix, rd_a, rd_b, opa, opb;
  logic signed [W-1:0] scratch [0:31];

  alu_cmd_t            cmd;
  logic signed [W-1:0] alu_res;
  logic                alu_clip, div_done;
  logic                mem_we;
  logic signed [63:0]  fin64;

  function automatic logic signed [W-1:0] fix_sel(input logic [5:0] idx);
    unique case (idx)
      S_W:     return w;
      S_TX:    return tx;
      S_TY:    return ty;
      S_TZ:    return tz;
      S_LTI:   return lti;
      S_P:     return p;
      S_PX:    return px;
      S_PY:    return py;
      S_PZ:    return pz;
      S_LPI:   return lpi;
      S_PU:    return pu;
      S_PGX:   return pgx;
      S_PGY:   return pgy;
      S_PGZ:   return pgz;
      S_PLAP:  return plap;
      S_PRAD:  return prad;
      S_EPS:   return eps_w;
      S_CUR:   return cur_w;
      S_ONE:   return ONE_W;
      default: return '0;
    endcase
  endfunction

  always_comb begin
    if (64'({33'b0, epsilon}) > WMAX64) eps_w = W'(WMAX64);
    else if (epsilon == '0) eps_w = W'(1);
    else eps_w = W'({33'b0, epsilon});
    cur_w = word_in(curvature);
    ufetch = ucode(pc);
    opa = uop.sa[5] ? rd_a : opa_fix;
    opb = uop.sb[5] ? rd_b : opb_fix;
    cmd.op = uop.op;
    cmd.k = uop.k;
    cmd.start = (state == ST_EXEC) && (uop.op == OP_DIV);
    mem_we = ((state == ST_EXEC) && (uop.op == OP_ADD || uop.op == OP_SUB ||
              uop.op == OP_SCL || uop.op == OP_MUL)) || ((state == ST_DIVW) && div_done);
    fin64 = 64'(opa);
    item.ready = (state == ST_IDLE);
    result.valid = (state == ST_OUT);
    result.data = out_item;
  end

  vbrj_alu #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_alu (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .a        (opa),
    .b        (opb),
    .res      (alu_res),
    .res_clip (alu_clip),
    .div_done (div_done)
  );

  always_ff @(posedge clk) begin
    if (state == ST_FETCH) begin
      rd_a <= scratch[ufetch.sa[4:0]];
      rd_b <= scratch[ufetch.sb[4:0]];
    end
    if (mem_we) scratch[uop.dst] <= alu_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= 31'(ONE64);
      curvature <= '0;
      axisymmetric <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EPSILON:   epsilon <= cfg_data[30:0];
        CFG_CURVATURE: curvature <= cfg_data;
        CFG_AXISYM:    axisymmetric <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc <= '0;
      is_jac <= 1'b0;
      clip <= 1'b0;
      pu <= '0;
      pgx <= '0;
      pgy <= '0;
      pgz <= '0;
      plap <= '0;
      prad <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item.valid) begin
            if (item.data.opcode == CMD_LOAD) begin
              pu <= word_in(item.data.a_value);
              pgx <= word_in(item.data.a_grad_x);
              pgy <= word_in(item.data.a_grad_y);
              pgz <= word_in(item.data.a_grad_z);
              plap <= word_in(item.data.a_laplacian);
              prad <= word_in(item.data.radius);
            end else if (item.data.opcode == CMD_RES || item.data.opcode == CMD_JAC) begin
              w <= word_in(item.data.a_value);
              tx <= word_in(item.data.a_grad_x);
              ty <= word_in(item.data.a_grad_y);
              tz <= word_in(item.data.a_grad_z);
              lti <= word_in(item.data.a_laplacian);
              p <= word_in(item.data.b_value);
              px <= word_in(item.data.b_grad_x);
              py <= word_in(item.data.b_grad_y);
              pz <= word_in(item.data.b_grad_z);
              lpi <= word_in(item.data.b_laplacian);
              is_jac <= (item.data.opcode == CMD_JAC);
              pc <= '0;
              clip <= ONE_CLIP;
              if (axisymmetric && prad == '0) begin
                out_item <= '{entry_value: 32'd0, radius_fault: 1'b1, saturated: 1'b0};
                state <= ST_OUT;
              end else begin
                state <= ST_FETCH;
              end
            end
          end
        end
        ST_FETCH: begin
          if (ufetch.axi && !axisymmetric) begin
            pc <= pc + 7'd1;
          end else begin
            uop <= ufetch;
            opa_fix <= fix_sel(ufetch.sa);
            opb_fix <= fix_sel(ufetch.sb);
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          unique case (uop.op)
            OP_BR: begin
              pc <= is_jac ? JAC_PC : pc + 7'd1;
              state <= ST_FETCH;
            end
            OP_END: begin
              out_item.radius_fault <= 1'b0;
              if (fin64 > OMAX64) begin
                out_item.entry_value <= 32'(OMAX64);
                out_item.saturated <= 1'b1;
              end else if (fin64 < OMIN64) begin
                out_item.entry_value <= 32'(OMIN64);
                out_item.saturated <= 1'b1;
              end else begin
                out_item.entry_value <= 32'(fin64);
                out_item.saturated <= clip;
              end
              state <= ST_OUT;
            end
            OP_DIV: state <= ST_DIVW;
            default: begin
              clip <= clip | alu_clip;
              pc <= pc + 7'd1;
              state <= ST_FETCH;
            end
          endcase
        end
        ST_DIVW: begin
          if (div_done) begin
            clip <= clip | alu_clip;
            pc <= pc + 7'd1;
            state <= ST_FETCH;
          end
        end
        ST_OUT: begin
          if (result.ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== bench/vesicle_bending_residual_jacobian_tb.sv =====
// Self-checking testbench for the vesicle bending residual/jacobian entry unit.
`timescale 1ns / 100ps
module vesicle_bending_residual_jacobian_tb;
  import vbrj_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int WD_LIMIT = 6000;
  localparam int DRAIN_CYCLES = 500;
  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_EPSILON;
  logic [31:0] cfg_data = '0;

  vbrj_chan #(.T(item_t)) item_if ();
  vbrj_chan #(.T(result_t)) res_if ();

  vesicle_bending_residual_jacobian dut (
    .clk(clk), .rst(rst), .item(item_if), .result(res_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  item_t pending_items[$];
  result_t entry_expect_q[$];
  int errors = 0;

  // register and point-state copies
  longint eps_reg = 65536, curv_reg = 0;
  bit axi_reg = 1'b0;
  longint pt_u = 0, pt_gx = 0, pt_gy = 0, pt_gz = 0, pt_lap = 0, pt_rad = 0;
  bit clip_seen;

  function automatic longint sx(input logic [31:0] x);
    return longint'($signed(x));
  endfunction

  function automatic longint from_mag(input bit neg, input longint unsigned mag);
    longint unsigned lim;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (mag > lim) begin
      mag = lim;
      clip_seen = 1'b1;
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint fx_sat(input longint v);
    if (v > WMAX) begin clip_seen = 1'b1; return WMAX; end
    if (v < WMIN) begin clip_seen = 1'b1; return WMIN; end
    return v;
  endfunction

  function automatic longint fx_add(input longint a, input longint b);
    return fx_sat(a + b);
  endfunction

  function automatic longint fx_sub(input longint a, input longint b);
    return fx_sat(a - b);
  endfunction

  function automatic longint fx_scl(input longint a, input longint k);
    return fx_sat(a * k);
  endfunction

  function automatic longint unsigned mag(input longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    longint unsigned p;
    p = mag(a) * mag(b);
    return from_mag((a < 0) != (b < 0), (p + 64'd32768) >> 16);
  endfunction

  function automatic longint fx_div(input longint a, input longint b);
    longint unsigned n, d, q, r;
    d = mag(b);
    if (d == 0) return 0;
    n = mag(a) << 16;
    q = n / d;
    r = n % d;
    if (r >= d - r) q++;
    return from_mag((a < 0) != (b < 0), q);
  endfunction

  function automatic longint dot3(input longint ax, ay, az, bx, by, bz);
    return fx_add(fx_add(fx_mul(ax, bx), fx_mul(ay, by)), fx_mul(az, bz));
  endfunction

  // returns 1 when the item yields an entry
  function automatic bit predict_entry(input item_t it, output result_t res);
    longint w, tx, ty, tz, lt, p, px, py, pz, lp, lu, eps, one, ce, u2, g, h, k;
    longint ie, i2, ie3, dtu, duu, s6u, r, dtp, dpu, m;
    res = '0;
    if (it.opcode == CMD_LOAD) begin
      pt_u = sx(it.a_value);
      pt_gx = sx(it.a_grad_x);
      pt_gy = sx(it.a_grad_y);
      pt_gz = sx(it.a_grad_z);
      pt_lap = sx(it.a_laplacian);
      pt_rad = sx(it.radius);
      return 1'b0;
    end
    if (it.opcode == CMD_NOP) return 1'b0;
    w = sx(it.a_value); tx = sx(it.a_grad_x); ty = sx(it.a_grad_y);
    tz = sx(it.a_grad_z); lt = sx(it.a_laplacian);
    p = sx(it.b_value); px = sx(it.b_grad_x); py = sx(it.b_grad_y);
    pz = sx(it.b_grad_z); lp = sx(it.b_laplacian);
    clip_seen = 1'b0;
    if (axi_reg && pt_rad == 0) begin
      res.radius_fault = 1'b1;
      return 1'b1;
    end
    lu = pt_lap;
    eps = eps_reg > 0 ? eps_reg : 1;
    one = 65536;
    if (axi_reg) begin
      lu = fx_add(lu, fx_div(pt_gx, pt_rad));
      lt = fx_add(lt, fx_div(tx, pt_rad));
      lp = fx_add(lp, fx_div(px, pt_rad));
    end
    ce = fx_mul(curv_reg, eps);
    u2 = fx_mul(pt_u, pt_u);
    g = fx_sub(fx_add(fx_scl(u2, 3), fx_scl(fx_mul(ce, pt_u), 2)), one);
    h = fx_sub(u2, one);
    k = fx_add(pt_u, ce);
    ie = fx_div(one, eps);
    i2 = fx_div(fx_scl(one, 2), eps);
    ie3 = fx_mul(fx_mul(ie, ie), ie);
    dtu = dot3(tx, ty, tz, pt_gx, pt_gy, pt_gz);
    duu = dot3(pt_gx, pt_gy, pt_gz, pt_gx, pt_gy, pt_gz);
    s6u = fx_add(fx_scl(pt_u, 6), fx_scl(ce, 2));
    if (it.opcode == CMD_RES) begin
      r = fx_mul(eps, fx_mul(lt, lu));
      r = fx_add(r, fx_mul(fx_mul(i2, dtu), g));
      r = fx_add(r, fx_mul(fx_mul(fx_mul(ie, w), s6u), duu));
      r = fx_add(r, fx_mul(fx_mul(fx_mul(fx_mul(ie3, w), g), h), k));
    end else begin
      dtp = dot3(tx, ty, tz, px, py, pz);
      dpu = dot3(px, py, pz, pt_gx, pt_gy, pt_gz);
      m = fx_add(fx_mul(fx_scl(pt_u, 6), p), fx_mul(fx_scl(ce, 2), p));
      r = fx_mul(fx_mul(eps, lt), lp);
      r = fx_add(r, fx_mul(fx_mul(i2, dtp), g));
      r = fx_add(r, fx_mul(fx_mul(i2, dtu), m));
      r = fx_add(r, fx_mul(fx_mul(fx_mul(ie, w), fx_scl(p, 6)), duu));
      r = fx_add(r, fx_mul(fx_mul(fx_mul(ie, w), s6u), fx_scl(dpu, 2)));
      r = fx_add(r, fx_mul(fx_mul(fx_mul(fx_mul(ie3, w), m), h), k));
      r = fx_add(r, fx_mul(fx_mul(fx_mul(fx_mul(ie3, w), g), fx_mul(fx_scl(pt_u, 2), p)), k));
      r = fx_add(r, fx_mul(fx_mul(fx_mul(fx_mul(ie3, w), g), h), p));
    end
    res.entry_value = r[31:0];
    res.saturated = clip_seen;
    return 1'b1;
  endfunction

  // driver: bursts with random gaps
  item_t drv_item = '0;
  logic drv_valid = 1'b0;
  int burst_left = 4, gap_left = 0;
  int unsigned items_taken = 0;
  assign item_if.valid = drv_valid;
  assign item_if.data = drv_item;

  always @(posedge clk) begin
    logic nv;
    result_t exp_res;
    nv = drv_valid;
    if (!rst) begin
      if (drv_valid && item_if.ready) begin
        if (predict_entry(drv_item, exp_res)) entry_expect_q.push_back(exp_res);
        items_taken++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) gap_left--;
        else if (pending_items.size() > 0) begin
          drv_item <= pending_items.pop_front();
          nv = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end
        end
      end
    end
    drv_valid <= nv;
  end

  // receiver: random stall pattern, redrawn whenever the stall counter wraps
  logic sink_ready = 1'b0;
  int stall_mode = 0, stall_cnt = 0;
  int unsigned results_taken = 0;
  assign res_if.ready = sink_ready;

  always @(posedge clk) begin
    result_t exp_res;
    if (stall_cnt == 0) stall_mode = $urandom_range(0, 3);
    stall_cnt = (stall_cnt + 1) % 64;
    case (stall_mode)
      0: sink_ready <= 1'b1;
      1: sink_ready <= $urandom_range(0, 1);
      2: sink_ready <= ($urandom_range(0, 7) == 0);
      default: sink_ready <= ($urandom_range(0, 3) != 0);
    endcase
    if (!rst && res_if.valid && sink_ready) begin
      results_taken++;
      if (entry_expect_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected entry transfer: %h", res_if.data);
      end else begin
        exp_res = entry_expect_q.pop_front();
        if (res_if.data.entry_value !== exp_res.entry_value ||
            res_if.data.radius_fault !== exp_res.radius_fault ||
            res_if.data.saturated !== exp_res.saturated) begin
          errors++;
          if (errors <= 10)
            $display("entry mismatch: exp val=%h fault=%b sat=%b got val=%h fault=%b sat=%b",
                     exp_res.entry_value, exp_res.radius_fault, exp_res.saturated,
                     res_if.data.entry_value, res_if.data.radius_fault,
                     res_if.data.saturated);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((drv_valid && item_if.ready) || (res_if.valid && sink_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WD_LIMIT) begin
      $display("vesicle_bending_residual_jacobian_tb: errors");
      $finish;
    end
  end

  function automatic logic [31:0] rand_word();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = $urandom;
      1: case ($urandom_range(0, 4))
           0: v = 32'h8000_0000;
           1: v = 32'h7fff_ffff;
           2: v = 32'h0;
           3: v = 32'hffff_ffff;
           default: v = 32'h0001_0000;
         endcase
      2: v = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      default: v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
    return v;
  endfunction

  function automatic item_t rand_item(input logic [1:0] op);
    item_t it;
    it = '0;
    it.opcode = op;
    it.a_value = rand_word(); it.a_grad_x = rand_word(); it.a_grad_y = rand_word();
    it.a_grad_z = rand_word(); it.a_laplacian = rand_word();
    it.b_value = rand_word(); it.b_grad_x = rand_word(); it.b_grad_y = rand_word();
    it.b_grad_z = rand_word(); it.b_laplacian = rand_word();
    it.radius = ($urandom_range(0, 7) == 0) ? 32'h0 : rand_word();
    return it;
  endfunction

  function automatic item_t fill_item(input logic [1:0] op, input logic [31:0] v);
    item_t it;
    it = {op, {11{v}}};
    return it;
  endfunction

  task automatic wait_idle();
    while (pending_items.size() > 0 || drv_valid || entry_expect_q.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_cfg(input logic [30:0] eps, input logic [31:0] cur, input bit axi);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_EPSILON; cfg_data <= {1'b0, eps};
    @(posedge clk);
    cfg_index <= CFG_CURVATURE; cfg_data <= cur;
    @(posedge clk);
    cfg_index <= CFG_AXISYM; cfg_data <= {31'b0, axi};
    @(posedge clk);
    cfg_we <= 1'b0;
    eps_reg = longint'(eps);
    curv_reg = sx(cur);
    axi_reg = axi;
  endtask

  task automatic push_sequences(input int n_items);
    int cnt, n;
    item_t it;
    cnt = 0;
    while (cnt < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        pending_items.push_back(rand_item(CMD_LOAD));
        n = $urandom_range(1, 6);
        cnt += n + 1;
        repeat (n) pending_items.push_back(rand_item($urandom_range(0, 1) ? CMD_RES : CMD_JAC));
      end else begin
        it = rand_item(2'($urandom_range(0, 3)));
        pending_items.push_back(it);
        if (it.opcode != CMD_NOP) cnt++;
      end
    end
  endtask

  initial begin
    logic [30:0] eps;
    logic [31:0] cur;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: reset state, extremes, unused opcode, zero radius
    pending_items.push_back(fill_item(CMD_RES, 32'h0001_0000));
    pending_items.push_back(fill_item(CMD_JAC, 32'h0001_0000));
    pending_items.push_back(fill_item(CMD_NOP, 32'hdead_beef));
    pending_items.push_back(fill_item(CMD_LOAD, 32'h7fff_ffff));
    pending_items.push_back(fill_item(CMD_RES, 32'h7fff_ffff));
    pending_items.push_back(fill_item(CMD_JAC, 32'h8000_0000));
    pending_items.push_back(fill_item(CMD_LOAD, 32'h8000_0000));
    pending_items.push_back(fill_item(CMD_RES, 32'hffff_ffff));
    pending_items.push_back(fill_item(CMD_LOAD, 32'h0000_8000));
    pending_items.push_back(fill_item(CMD_RES, 32'h0001_8000));
    pending_items.push_back(fill_item(CMD_JAC, 32'hfffe_8000));
    pending_items.push_back(fill_item(CMD_LOAD, 32'h0));
    pending_items.push_back(fill_item(CMD_JAC, 32'h0002_0000));
    apply_cfg(31'h0001_0000, 32'h0, 1'b1);
    pending_items.push_back(fill_item(CMD_RES, 32'h0001_0000));
    pending_items.push_back(fill_item(CMD_JAC, 32'h0001_0000));
    pending_items.push_back(fill_item(CMD_LOAD, 32'h0002_0000));
    pending_items.push_back(fill_item(CMD_RES, 32'h0000_4000));
    pending_items.push_back(fill_item(CMD_JAC, 32'hffff_c000));
    apply_cfg(31'h1, 32'h8000_0000, 1'b0);
    pending_items.push_back(fill_item(CMD_RES, 32'h0000_4000));
    pending_items.push_back(fill_item(CMD_JAC, 32'h0000_4000));
    apply_cfg(31'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    pending_items.push_back(fill_item(CMD_RES, 32'h0000_4000));
    pending_items.push_back(fill_item(CMD_JAC, 32'hffff_c000));

    // random phases, each under its own setting
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin eps = 31'h0001_0000; cur = 32'h0; end
        1: begin eps = 31'h1; cur = 32'h0001_0000; end
        2: begin eps = 31'h7fff_ffff; cur = 32'h8000_0000; end
        default: begin
          eps = ($urandom_range(0, 4) == 0) ? 31'($urandom)
                                            : 31'($urandom_range(16384, 262144));
          cur = ($urandom_range(0, 4) == 0) ? $urandom
                                            : $urandom_range(0, 32'h40000) - 32'h20000;
        end
      endcase
      apply_cfg(eps, cur, 1'(ph % 2));
      push_sequences(132);
    end

    wait_idle();
    if (errors == 0) $display("vesicle_bending_residual_jacobian_tb: clean");
    else $display("vesicle_bending_residual_jacobian_tb: errors");
    $finish;
  end

endmodule
